/* hdl/csd_pkg.sv */
package csd_pkg;

    // payload widths of the channels
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 16;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [OUT_W-1:0]  t_field;

    // framing and token characters
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_NL     = 8'h0A;
    localparam t_byte CH_COMMA  = 8'h2C;
    localparam t_byte CH_NUL    = 8'h00;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_NINE   = 8'h39;
    localparam t_byte CH_UP_A   = 8'h41;
    localparam t_byte CH_UP_F   = 8'h46;
    localparam t_byte CH_LO_A   = 8'h61;
    localparam t_byte CH_LO_F   = 8'h66;

    // hex letter offsets
    localparam t_byte HEX_UP_OFS = 8'd55;
    localparam t_byte HEX_LO_OFS = 8'd87;

    // message ids
    localparam logic [23:0] ID_COO = 24'h434F4F;
    localparam logic [23:0] ID_HIT = 24'h484954;
    localparam logic [23:0] ID_CHA = 24'h434841;
    localparam logic [23:0] ID_DET = 24'h444554;

    // token counts per id
    localparam logic [2:0] TOK_MAX  = 3'd7;
    localparam logic [2:0] TOK_NEED = 3'd2;
    localparam logic [2:0] TOK_HIT  = 3'd3;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_REC  = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3,
        PH_NL   = 3'd4
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_WAIT = 3'd0,
        ST_GOOD = 3'd1,
        ST_FAIL = 3'd2,
        ST_COO  = 3'd3,
        ST_HIT  = 3'd4,
        ST_CHA  = 3'd5,
        ST_DET  = 3'd6
    } t_status;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // one hex digit, upper or lower case
    function automatic t_hex hex_decode(input t_byte c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.val = 4'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            h.val = 4'(c - HEX_UP_OFS);
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            h.val = 4'(c - HEX_LO_OFS);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* hdl/csd_if.sv */
// byte request channel
interface csd_in_if;
    import csd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte byte_in;

    modport source(output valid, output byte_in, input ready);
    modport sink(input valid, input byte_in, output ready);
endinterface

// status request channel
interface csd_out_if;
    import csd_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_field  field_a;
    t_field  field_b;
    t_field  field_c;

    modport source(output valid, output status, output field_a, output field_b,
                   output field_c, input ready);
    modport sink(input valid, input status, input field_a, input field_b,
                 input field_c, output ready);
endinterface

/* hdl/checksummed_sentence_decoder_core.sv */
// Sentence decoder for "$payload*HH" + newline text, one character per request.
// i_req (sink) carries one byte per request; o_rsp (source) returns exactly one
// status request for every byte taken, in order.
// Status: 0 waiting for '$', 1 byte taken, 2 failure (sentence dropped),
// 3..6 COO/HIT/CHA/DET parsed on the newline with field_a/b (and field_c on HIT).
// Output: the status is registered and shows on o_rsp in the cycle after its
// byte is accepted. Throughput: one byte per cycle while o_rsp is not stalled;
// the whole decode step (checksum XOR, id capture, token split, times-ten
// field update, id match) sits between the byte and the output register.
// Stall: i_req.ready follows o_rsp.ready while a status is held, so a stalled
// receiver holds the byte stream back without loss; with the output register
// empty a byte is taken regardless.
// Reset (i_rst_n low, synchronous): back to waiting for '$' with all
// sentence state cleared and the output register empty.
// MAX_PAYLOAD bytes may sit between '$' and '*'; a longer payload fails.
// FIELD_BITS is the accumulator width; fields wrap modulo 2^FIELD_BITS and
// report their low 16 bits.
module checksummed_sentence_decoder_core #(
    parameter int MAX_PAYLOAD = 64,
    parameter int FIELD_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csd_in_if.sink    i_req,
    csd_out_if.source o_rsp
);
    import csd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    // sentence state
    t_phase                 r_phase, n_phase;
    logic [CNT_W-1:0]       r_count, n_count;
    t_byte                  r_xor, n_xor;
    logic [3:0]             r_sum_hi, n_sum_hi;
    logic [2:0][7:0]        r_id, n_id;
    logic [2:0]             r_tok, n_tok;
    logic                   r_in_tok, n_in_tok;
    logic                   r_done, n_done;
    logic                   r_nul, n_nul;
    logic [FIELD_BITS-1:0]  r_field [3];
    logic [FIELD_BITS-1:0]  n_field [3];

    // output register
    logic    r_out_valid;
    t_status r_status;
    t_field  r_fa, r_fb, r_fc;

    // step logic
    logic                  in_fire;
    t_byte                 c;
    t_hex                  hx;
    t_status               st;
    logic                  parsed;
    logic [1:0]            k;
    logic [FIELD_BITS-1:0] cur;

    assign c           = i_req.byte_in;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign in_fire     = i_req.valid && i_req.ready;

    // next state and status for one byte
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_xor    = r_xor;
        n_sum_hi = r_sum_hi;
        n_id     = r_id;
        n_tok    = r_tok;
        n_in_tok = r_in_tok;
        n_done   = r_done;
        n_nul    = r_nul;
        n_field  = r_field;
        st       = ST_GOOD;
        hx       = hex_decode(c);
        k        = 2'd0;
        cur      = '0;
        case (r_phase)
            PH_WAIT: begin
                if (c == CH_DOLLAR) begin
                    n_phase    = PH_REC;
                    n_count    = '0;
                    n_xor      = '0;
                    n_sum_hi   = '0;
                    n_id       = '0;
                    n_tok      = '0;
                    n_in_tok   = 1'b0;
                    n_done     = 1'b0;
                    n_nul      = 1'b0;
                    n_field[0] = '0;
                    n_field[1] = '0;
                    n_field[2] = '0;
                end else begin
                    st = ST_WAIT;
                end
            end
            PH_REC: begin
                if (c == CH_STAR) begin
                    n_phase = PH_HEX1;
                end else if (r_count >= CNT_W'(MAX_PAYLOAD)) begin
                    n_phase = PH_WAIT;
                    st      = ST_FAIL;
                end else begin
                    n_count = r_count + 1'b1;
                    if (!r_nul) begin
                        if (c == CH_NUL) begin
                            n_nul = 1'b1;
                        end else begin
                            n_xor = r_xor ^ c;
                            if (r_count < CNT_W'(3)) begin
                                // id characters, first one in the top byte
                                n_id[2'd2 - r_count[1:0]] = c;
                            end else if (r_count != CNT_W'(3)) begin
                                if (c == CH_COMMA) begin
                                    n_in_tok = 1'b0;
                                end else begin
                                    // a new token opens
                                    if (!r_in_tok) begin
                                        n_in_tok = 1'b1;
                                        n_done   = 1'b0;
                                        if (r_tok != TOK_MAX) begin
                                            n_tok = r_tok + 3'd1;
                                        end
                                        if (n_tok <= TOK_HIT) begin
                                            n_field[2'(n_tok - 3'd1)] = '0;
                                        end
                                    end
                                    // leading decimal digits, times ten plus digit
                                    if (!n_done) begin
                                        if (c >= CH_ZERO && c <= CH_NINE) begin
                                            if (n_tok <= TOK_HIT) begin
                                                k          = 2'(n_tok - 3'd1);
                                                cur        = n_field[k];
                                                n_field[k] = FIELD_BITS'((cur << 3)
                                                    + (cur << 1)
                                                    + FIELD_BITS'(c - CH_ZERO));
                                            end
                                        end else begin
                                            n_done = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
            end
            PH_HEX1: begin
                if (!hx.ok) begin
                    n_phase = PH_WAIT;
                    st      = ST_FAIL;
                end else begin
                    n_sum_hi = hx.val;
                    n_phase  = PH_HEX2;
                end
            end
            PH_HEX2: begin
                if (!hx.ok || {r_sum_hi, hx.val} != r_xor) begin
                    n_phase = PH_WAIT;
                    st      = ST_FAIL;
                end else begin
                    n_phase = PH_NL;
                end
            end
            PH_NL: begin
                n_phase = PH_WAIT;
                if (c != CH_NL) begin
                    st = ST_FAIL;
                end else if (r_id == ID_COO && r_tok == TOK_NEED) begin
                    st = ST_COO;
                end else if (r_id == ID_HIT && r_tok == TOK_HIT) begin
                    st = ST_HIT;
                end else if (r_id == ID_CHA && r_tok == TOK_NEED) begin
                    st = ST_CHA;
                end else if (r_id == ID_DET && r_tok == TOK_NEED) begin
                    st = ST_DET;
                end else begin
                    st = ST_FAIL;
                end
            end
            default: begin
                n_phase = PH_WAIT;
                st      = ST_FAIL;
            end
        endcase
    end

    assign parsed = (st == ST_COO) || (st == ST_HIT) || (st == ST_CHA) || (st == ST_DET);

    // sentence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_count    <= '0;
            r_xor      <= '0;
            r_sum_hi   <= '0;
            r_id       <= '0;
            r_tok      <= '0;
            r_in_tok   <= 1'b0;
            r_done     <= 1'b0;
            r_nul      <= 1'b0;
            r_field[0] <= '0;
            r_field[1] <= '0;
            r_field[2] <= '0;
        end else if (in_fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_xor    <= n_xor;
            r_sum_hi <= n_sum_hi;
            r_id     <= n_id;
            r_tok    <= n_tok;
            r_in_tok <= n_in_tok;
            r_done   <= n_done;
            r_nul    <= n_nul;
            r_field  <= n_field;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status <= st;
            r_fa     <= parsed ? OUT_W'(r_field[0]) : '0;
            r_fb     <= parsed ? OUT_W'(r_field[1]) : '0;
            r_fc     <= (st == ST_HIT) ? OUT_W'(r_field[2]) : '0;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_status;
    assign o_rsp.field_a = r_fa;
    assign o_rsp.field_b = r_fb;
    assign o_rsp.field_c = r_fc;

    // a '$' while waiting opens an empty sentence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_phase == PH_WAIT && c == CH_DOLLAR
        |=> r_phase == PH_REC && r_count == '0 && r_tok == '0)
        else $error("start of sentence not taken");

    // payload length never passes the limit
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond limit");

    // the byte after the checksum always closes the sentence
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_phase == PH_NL |=> r_phase == PH_WAIT)
        else $error("sentence not closed after newline slot");

    // third field only on a HIT result
    a_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_HIT |-> r_fc == '0)
        else $error("field_c set outside HIT");

    // an empty output register never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("input blocked with empty output");

endmodule
